@@ src/nlmc_pkg.sv @@
// Package for the neighbor label multiset check: defaults, mode codes, chain structs.
package nlmc_pkg;

    localparam int MAX_DEGREE_DEF = 32;
    localparam int LABEL_BITS_DEF = 8;
    localparam int MODE_W  = 3;
    localparam int INLBL_W = 8;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_GIN  = 3'd0;
    localparam t_mode MODE_GOUT = 3'd1;
    localparam t_mode MODE_QIN  = 3'd2;
    localparam t_mode MODE_QOUT = 3'd3;
    localparam t_mode MODE_EVAL = 3'd4;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic shift_in;
        logic shift_out;
        logic clr;
    } t_ctl;

    // search token moving down the chain; sel picks the out-lists
    typedef struct packed {
        logic vld;
        logic sel;
    } t_tok;

endpackage

@@ src/nlmc_cell.sv @@
// One chain cell: a graph in/out label slot with used marks and a search token stage.
module nlmc_cell #(
    parameter int LABEL_BITS = nlmc_pkg::LABEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nlmc_pkg::t_ctl        i_ctl,
    input  logic [LABEL_BITS-1:0] i_gin_lbl,
    input  logic                  i_gin_vld,
    input  logic [LABEL_BITS-1:0] i_gout_lbl,
    input  logic                  i_gout_vld,
    output logic [LABEL_BITS-1:0] o_gin_lbl,
    output logic                  o_gin_vld,
    output logic [LABEL_BITS-1:0] o_gout_lbl,
    output logic                  o_gout_vld,
    input  nlmc_pkg::t_tok        i_tok,
    input  logic [LABEL_BITS-1:0] i_tok_lbl,
    output nlmc_pkg::t_tok        o_tok,
    output logic [LABEL_BITS-1:0] o_tok_lbl
);

    logic [LABEL_BITS-1:0] r_gin_lbl;
    logic [LABEL_BITS-1:0] r_gout_lbl;
    logic                  r_gin_vld;
    logic                  r_gout_vld;
    logic                  r_used_in;
    logic                  r_used_out;
    nlmc_pkg::t_tok        r_tok;
    logic [LABEL_BITS-1:0] r_tok_lbl;
    logic                  hit_in;
    logic                  hit_out;

    assign hit_in  = i_tok.vld && !i_tok.sel && r_gin_vld && !r_used_in
                     && (r_gin_lbl == i_tok_lbl);
    assign hit_out = i_tok.vld && i_tok.sel && r_gout_vld && !r_used_out
                     && (r_gout_lbl == i_tok_lbl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gin_vld  <= 1'b0;
            r_gout_vld <= 1'b0;
            r_used_in  <= 1'b0;
            r_used_out <= 1'b0;
            r_tok      <= '0;
        end else begin
            r_tok.vld <= i_tok.vld && !(hit_in || hit_out);
            r_tok.sel <= i_tok.sel;
            if (i_ctl.clr) begin
                r_gin_vld  <= 1'b0;
                r_gout_vld <= 1'b0;
                r_used_in  <= 1'b0;
                r_used_out <= 1'b0;
            end else begin
                if (i_ctl.shift_in) begin
                    r_gin_vld <= i_gin_vld;
                end
                if (i_ctl.shift_out) begin
                    r_gout_vld <= i_gout_vld;
                end
                if (hit_in) begin
                    r_used_in <= 1'b1;
                end
                if (hit_out) begin
                    r_used_out <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_lbl <= i_tok_lbl;
        if (i_ctl.shift_in) begin
            r_gin_lbl <= i_gin_lbl;
        end
        if (i_ctl.shift_out) begin
            r_gout_lbl <= i_gout_lbl;
        end
    end

    assign o_gin_lbl  = r_gin_lbl;
    assign o_gin_vld  = r_gin_vld;
    assign o_gout_lbl = r_gout_lbl;
    assign o_gout_vld = r_gout_vld;
    assign o_tok      = r_tok;
    assign o_tok_lbl  = r_tok_lbl;

endmodule

@@ src/neighbor_label_multiset_check.sv @@
// Top level of the neighbor label multiset check: list loading, query feed, cell chain.
//
//  channel  | signals                          | direction | payload
//  ---------+----------------------------------+-----------+--------------------
//  in       | i_in_valid / o_in_ready          | sink      | i_mode, i_label
//  out      | o_out_valid / i_out_ready        | source    | o_pass, o_overflow
//
//  Loads are taken while the block is idle. An evaluate with an empty query in-list goes
//  straight to the result; otherwise the query labels enter the cell chain one per cycle
//  and the last one crosses all MAX_DEGREE cells before the result is formed.
//  Reset is synchronous, active low; all lists come up empty, no clearing pass.
//  A held result does not stall loads; only the next result waits for its transfer.
module neighbor_label_multiset_check #(
    parameter int MAX_DEGREE = nlmc_pkg::MAX_DEGREE_DEF,
    parameter int LABEL_BITS = nlmc_pkg::LABEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [nlmc_pkg::MODE_W-1:0]   i_mode,
    input  logic [nlmc_pkg::INLBL_W-1:0]  i_label,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_pass,
    output logic                          o_overflow
);

    localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DEGREE);

    typedef enum logic [1:0] {S_IDLE, S_FEED, S_DRAIN, S_DONE} t_state;

    t_state                r_state;
    logic [CW-1:0]         r_cnt_gin;
    logic [CW-1:0]         r_cnt_gout;
    logic [CW-1:0]         r_cnt_qin;
    logic [CW-1:0]         r_cnt_qout;
    logic                  r_ovf_seen;
    logic [IW-1:0]         r_idx;
    logic                  r_sel;
    logic [CW-1:0]         r_drn;
    logic                  r_fail;
    logic                  r_rd_vld;
    logic                  r_rd_sel;
    logic                  r_out_vld;
    logic                  r_pass;
    logic                  r_ovf;
    logic [LABEL_BITS-1:0] r_qin_q;
    logic [LABEL_BITS-1:0] r_qout_q;
    logic [LABEL_BITS-1:0] mem_qin  [MAX_DEGREE];
    logic [LABEL_BITS-1:0] mem_qout [MAX_DEGREE];

    logic [LABEL_BITS-1:0] w_lbl;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  done_go;
    logic                  ld_gin;
    logic                  ld_gout;
    logic                  ld_qin;
    logic                  ld_qout;
    logic [CW-1:0]         idx_next;
    logic [CW-1:0]         cur_cnt;
    nlmc_pkg::t_ctl        ctl;
    nlmc_pkg::t_tok        tok_head;
    logic [LABEL_BITS-1:0] tok_head_lbl;

    logic [LABEL_BITS-1:0] gin_lbl  [MAX_DEGREE+1];
    logic                  gin_vld  [MAX_DEGREE+1];
    logic [LABEL_BITS-1:0] gout_lbl [MAX_DEGREE+1];
    logic                  gout_vld [MAX_DEGREE+1];
    nlmc_pkg::t_tok        tok      [MAX_DEGREE+1];
    logic [LABEL_BITS-1:0] tok_lbl  [MAX_DEGREE+1];

    generate
        if (LABEL_BITS >= nlmc_pkg::INLBL_W) begin : g_lbl_wide
            assign w_lbl = LABEL_BITS'(i_label);
        end else begin : g_lbl_narrow
            assign w_lbl = i_label[LABEL_BITS-1:0];
        end
    endgenerate

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_vld && i_out_ready;
    assign done_go    = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    assign ld_gin  = in_xfer && (i_mode == nlmc_pkg::MODE_GIN)  && (r_cnt_gin  != CNT_MAX);
    assign ld_gout = in_xfer && (i_mode == nlmc_pkg::MODE_GOUT) && (r_cnt_gout != CNT_MAX);
    assign ld_qin  = in_xfer && (i_mode == nlmc_pkg::MODE_QIN)  && (r_cnt_qin  != CNT_MAX);
    assign ld_qout = in_xfer && (i_mode == nlmc_pkg::MODE_QOUT) && (r_cnt_qout != CNT_MAX);

    assign idx_next = CW'(r_idx) + CW'(1);
    assign cur_cnt  = r_sel ? r_cnt_qout : r_cnt_qin;

    assign ctl.shift_in  = ld_gin;
    assign ctl.shift_out = ld_gout;
    assign ctl.clr       = done_go;

    assign tok_head.vld  = r_rd_vld;
    assign tok_head.sel  = r_rd_sel;
    assign tok_head_lbl  = r_rd_sel ? r_qout_q : r_qin_q;

    assign gin_lbl[0]  = w_lbl;
    assign gin_vld[0]  = 1'b1;
    assign gout_lbl[0] = w_lbl;
    assign gout_vld[0] = 1'b1;
    assign tok[0]      = tok_head;
    assign tok_lbl[0]  = tok_head_lbl;

    generate
        for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_cell
            nlmc_cell #(
                .LABEL_BITS (LABEL_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_gin_lbl  (gin_lbl[j]),
                .i_gin_vld  (gin_vld[j]),
                .i_gout_lbl (gout_lbl[j]),
                .i_gout_vld (gout_vld[j]),
                .o_gin_lbl  (gin_lbl[j+1]),
                .o_gin_vld  (gin_vld[j+1]),
                .o_gout_lbl (gout_lbl[j+1]),
                .o_gout_vld (gout_vld[j+1]),
                .i_tok      (tok[j]),
                .i_tok_lbl  (tok_lbl[j]),
                .o_tok      (tok[j+1]),
                .o_tok_lbl  (tok_lbl[j+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (ld_qin) begin
            mem_qin[r_cnt_qin[IW-1:0]] <= w_lbl;
        end
        if (ld_qout) begin
            mem_qout[r_cnt_qout[IW-1:0]] <= w_lbl;
        end
        r_qin_q  <= mem_qin[r_idx];
        r_qout_q <= mem_qout[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt_gin  <= '0;
            r_cnt_gout <= '0;
            r_cnt_qin  <= '0;
            r_cnt_qout <= '0;
            r_ovf_seen <= 1'b0;
            r_idx      <= '0;
            r_sel      <= 1'b0;
            r_drn      <= '0;
            r_fail     <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_sel   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pass     <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_FEED);
            r_rd_sel <= r_sel;
            if (done_go) begin
                r_out_vld <= 1'b1;
            end else if (out_xfer) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_mode)
                            nlmc_pkg::MODE_GIN, nlmc_pkg::MODE_GOUT,
                            nlmc_pkg::MODE_QIN, nlmc_pkg::MODE_QOUT: begin
                                if (ld_gin)  r_cnt_gin  <= r_cnt_gin  + CW'(1);
                                if (ld_gout) r_cnt_gout <= r_cnt_gout + CW'(1);
                                if (ld_qin)  r_cnt_qin  <= r_cnt_qin  + CW'(1);
                                if (ld_qout) r_cnt_qout <= r_cnt_qout + CW'(1);
                                if (!(ld_gin || ld_gout || ld_qin || ld_qout)) begin
                                    r_ovf_seen <= 1'b1;
                                end
                            end
                            nlmc_pkg::MODE_EVAL: begin
                                r_fail <= 1'b0;
                                r_idx  <= '0;
                                r_sel  <= 1'b0;
                                r_drn  <= '0;
                                if (r_cnt_qin == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_FEED;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FEED: begin
                    r_fail <= r_fail | tok[MAX_DEGREE].vld;
                    if (idx_next == cur_cnt) begin
                        r_idx <= '0;
                        if (!r_sel && (r_cnt_qout != '0)) begin
                            r_sel <= 1'b1;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_idx <= idx_next[IW-1:0];
                    end
                end
                S_DRAIN: begin
                    r_fail <= r_fail | tok[MAX_DEGREE].vld;
                    r_drn  <= r_drn + CW'(1);
                    if (r_drn == CNT_MAX) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (done_go) begin
                        r_pass     <= !r_fail;
                        r_ovf      <= r_ovf_seen;
                        r_cnt_gin  <= '0;
                        r_cnt_gout <= '0;
                        r_cnt_qin  <= '0;
                        r_cnt_qout <= '0;
                        r_ovf_seen <= 1'b0;
                        r_sel      <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pass      = r_pass;
    assign o_overflow  = r_ovf;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_gin <= CNT_MAX) && (r_cnt_gout <= CNT_MAX)
        && (r_cnt_qin <= CNT_MAX) && (r_cnt_qout <= CNT_MAX))
        else $error("list count above capacity");

    a_chain_empty_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !tok[MAX_DEGREE].vld && !r_rd_vld)
        else $error("search token still in flight when result is formed");

    a_empty_qin_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_mode == nlmc_pkg::MODE_EVAL) && (r_cnt_qin == '0))
        |=> (r_state == S_DONE) && !r_fail)
        else $error("evaluate with empty query in-list did not go straight to result");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");

    a_lists_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_go |=> (r_cnt_gin == '0) && (r_cnt_qin == '0) && !r_ovf_seen
        && (r_state == S_IDLE))
        else $error("lists not cleared after evaluate");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the neighbor label multiset check: a directed table, an overflow fill, then random label sets.
module tb;
    import nlmc_pkg::*;

    localparam int    DEPTH        = MAX_DEGREE_DEF;
    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    RANDOM_ITEMS = 1700;
    localparam int    LST_GIN      = 0;
    localparam int    LST_GOUT     = 1;
    localparam int    LST_QIN      = 2;
    localparam int    LST_QOUT     = 3;
    localparam t_mode MODE_UNUSED5 = 3'd5;
    localparam t_mode MODE_UNUSED6 = 3'd6;
    localparam t_mode MODE_UNUSED7 = 3'd7;

    typedef struct {
        bit pass;
        bit ovf;
    } t_verdict;

    typedef struct {
        t_mode              mode;
        logic [INLBL_W-1:0] label;
        bit                 typed;
        bit                 pass;
        bit                 ovf;
    } t_stim_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [MODE_W-1:0]  i_mode      = '0;
    logic [INLBL_W-1:0] i_label     = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_pass;
    logic               o_overflow;

    bit pend_typed = 1'b0;
    bit pend_pass  = 1'b0;
    bit pend_ovf   = 1'b0;
    bit calm       = 1'b0;

    logic [INLBL_W-1:0] lists [4][DEPTH];
    int unsigned        fill [4] = '{default: 0};
    bit                 ovf_seen = 1'b0;
    t_verdict           verdict_q [$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 sent   = 0;

    neighbor_label_multiset_check uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_label     (i_label),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pass      (o_pass),
        .o_overflow  (o_overflow)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int want, int got);
        $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    // each query label claims the first unused equal graph label
    function automatic bit claims_all(int g, int q);
        bit used [DEPTH];
        bit found;
        for (int j = 0; j < DEPTH; j++) used[j] = 1'b0;
        for (int i = 0; i < int'(fill[q]); i++) begin
            found = 1'b0;
            for (int j = 0; j < int'(fill[g]); j++) begin
                if (!used[j] && lists[g][j] == lists[q][i]) begin
                    used[j] = 1'b1;
                    found   = 1'b1;
                    break;
                end
            end
            if (!found) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic fold_transfer(t_mode m, logic [INLBL_W-1:0] lb, bit typed, bit tp, bit to);
        t_verdict v;
        int       idx;
        case (m)
            MODE_GIN, MODE_GOUT, MODE_QIN, MODE_QOUT: begin
                idx = int'(m);
                if (fill[idx] >= DEPTH) begin
                    ovf_seen = 1'b1;
                end else begin
                    lists[idx][fill[idx]] = lb;
                    fill[idx]++;
                end
            end
            MODE_EVAL: begin
                v.pass = 1'b1;
                if (fill[LST_QIN] != 0)
                    v.pass = claims_all(LST_GIN, LST_QIN) && claims_all(LST_GOUT, LST_QOUT);
                v.ovf = ovf_seen;
                if (typed) begin
                    v.pass = tp;
                    v.ovf  = to;
                end
                verdict_q = {verdict_q, v};
                fill     = '{default: 0};
                ovf_seen = 1'b0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            fold_transfer(t_mode'(i_mode), i_label, pend_typed, pend_pass, pend_ovf);
    end

    always @(posedge i_clk) begin : out_check
        t_verdict v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result transfer with none pending", 0, 1);
            end else begin
                v = verdict_q.pop_front();
                if (o_pass !== v.pass)
                    report_mismatch("pass", int'(v.pass), int'(o_pass));
                if (o_overflow !== v.ovf)
                    report_mismatch("overflow", int'(v.ovf), int'(o_overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 8);
    end

    task automatic send(t_mode m, logic [INLBL_W-1:0] lb, bit typed = 0, bit tp = 0,
                        bit to = 0);
        while (!calm && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_label    <= lb;
        pend_typed <= typed;
        pend_pass  <= tp;
        pend_ovf   <= to;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [INLBL_W-1:0] pick_label(bit palette, int base);
        if (palette)
            return INLBL_W'(base ^ $urandom_range(0, 3));
        return INLBL_W'($urandom_range(0, 255));
    endfunction

    // one set of loads, with stray unused-mode words, followed by an evaluate
    task automatic run_group;
        logic [INLBL_W-1:0] lbl [4][$];
        logic [INLBL_W-1:0] pool [$];
        int                 n [4];
        int                 r, base, pick, k;
        bit                 palette, subset;
        r       = $urandom_range(99);
        palette = $urandom_range(1);
        base    = $urandom_range(0, 255);
        for (int i = 0; i < 4; i++) begin
            if (r < 80)      n[i] = $urandom_range(0, 6);
            else if (r < 95) n[i] = $urandom_range(0, DEPTH);
            else             n[i] = $urandom_range(DEPTH - 2, DEPTH + 4);
        end
        if ($urandom_range(9) == 0) n[LST_QIN] = 0;
        for (int g = LST_GIN; g <= LST_GOUT; g++)
            for (int i = 0; i < n[g]; i++) lbl[g] = {lbl[g], pick_label(palette, base)};
        for (int q = LST_QIN; q <= LST_QOUT; q++) begin
            subset = ($urandom_range(9) < 6);
            if (subset && r < 95) n[q] = $urandom_range(0, n[q - 2]);
            pool = lbl[q - 2];
            for (int i = 0; i < n[q]; i++) begin
                if (subset && pool.size() > 0 && $urandom_range(15) != 0) begin
                    pick = $urandom_range(0, pool.size() - 1);
                    lbl[q] = {lbl[q], pool[pick]};
                    pool.delete(pick);
                end else begin
                    lbl[q] = {lbl[q], pick_label(palette, base)};
                end
            end
        end
        while (lbl[0].size() + lbl[1].size() + lbl[2].size() + lbl[3].size() != 0) begin
            k = $urandom_range(0, 3);
            while (lbl[k].size() == 0) k = (k + 1) % 4;
            send(t_mode'(k), lbl[k].pop_front());
            sent++;
            if ($urandom_range(99) < 3)
                send(t_mode'($urandom_range(MODE_UNUSED5, MODE_UNUSED7)),
                     INLBL_W'($urandom_range(0, 255)));
        end
        send(MODE_EVAL, INLBL_W'($urandom_range(0, 255)));
        sent++;
        if ($urandom_range(49) == 0) drain();
    endtask

    t_stim_row dir_rows [22] = '{
        '{MODE_EVAL,    8'h00, 1, 1, 0},
        '{MODE_QOUT,    8'h05, 0, 0, 0},
        '{MODE_EVAL,    8'hFF, 1, 1, 0},
        '{MODE_GIN,     8'h00, 0, 0, 0},
        '{MODE_GIN,     8'hFF, 0, 0, 0},
        '{MODE_QIN,     8'hFF, 0, 0, 0},
        '{MODE_QIN,     8'h00, 0, 0, 0},
        '{MODE_GOUT,    8'hAA, 0, 0, 0},
        '{MODE_QOUT,    8'hAA, 0, 0, 0},
        '{MODE_EVAL,    8'h00, 0, 0, 0},
        '{MODE_GIN,     8'h55, 0, 0, 0},
        '{MODE_QIN,     8'h55, 0, 0, 0},
        '{MODE_QIN,     8'h55, 0, 0, 0},
        '{MODE_UNUSED7, 8'h55, 0, 0, 0},
        '{MODE_EVAL,    8'h00, 0, 0, 0},
        '{MODE_QIN,     8'h01, 0, 0, 0},
        '{MODE_GIN,     8'h01, 0, 0, 0},
        '{MODE_UNUSED5, 8'hAA, 0, 0, 0},
        '{MODE_UNUSED6, 8'h55, 0, 0, 0},
        '{MODE_QOUT,    8'h02, 0, 0, 0},
        '{MODE_EVAL,    8'hFF, 0, 0, 0},
        '{MODE_EVAL,    8'h00, 1, 1, 0}
    };

    initial begin
        logic [INLBL_W-1:0] la, lb;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send(dir_rows[i].mode, dir_rows[i].label, dir_rows[i].typed,
                 dir_rows[i].pass, dir_rows[i].ovf);

        // every list filled one past capacity; the extra loads are dropped
        for (int i = 0; i <= DEPTH; i++) begin
            la = INLBL_W'($urandom_range(0, 255));
            lb = INLBL_W'($urandom_range(0, 255));
            send(MODE_GIN, la);
            send(MODE_QIN, la);
            send(MODE_GOUT, lb);
            send(MODE_QOUT, lb);
        end
        send(MODE_EVAL, 8'h00, 1, 1, 1);
        drain();

        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 700 && sent < 1000);
            run_group();
        end
        calm = 1'b0;

        drain();
        repeat (3 * DEPTH + 20) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
